// ===== rtl/crc32_target_matcher_macros.svh =====
// Assertion macros used by the checker module of the CRC-32 target matcher.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef CRC32_TARGET_MATCHER_MACROS_SVH
`define CRC32_TARGET_MATCHER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRC32TM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crc32 target matcher check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRC32TM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crc32 target matcher check failed");

`endif

// ===== rtl/crc32tm_pkg.sv =====
// Package for the CRC-32 target matcher: item types, CRC constants, target ROM
// and the byte fold function. Has no dependencies.
package crc32tm_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam int unsigned ROM_WORDS       = 14;
  localparam int unsigned NUM_TARGETS_DEF = 14;
  localparam int unsigned IDX_W           = 4;

  localparam logic [31:0] TARGET_ROM [ROM_WORDS] = '{
    32'hEDCFE1F3, 32'h646BCD23, 32'h50F9AD57, 32'hF299B1E1,
    32'hC6A9B6E4, 32'h3280614C, 32'h93772B02, 32'hAB2C3A43,
    32'h2A0D936A, 32'h1BFA14D4, 32'h255D6F2F, 32'hC447F66B,
    32'h5AD96CF5, 32'hE964AD12
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0]      crc_value;
    logic             match_found;
    logic [IDX_W-1:0] match_index;
  } out_item_t;

  // Folds one byte into a reflected CRC, least significant bit first.
  function automatic logic [31:0] fold_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] v;
    v = crc ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

// ===== rtl/crc32_target_matcher.sv =====
// CRC-32 target matcher: byte-serial reflected CRC-32 with a compare against
// a fixed ROM of target words.
//
// Usage: one message byte per input item, with last_byte set on the final
// byte of each message. Bytes without the last flag only advance the running
// CRC and produce no result. A last byte produces one result item holding
// the complemented CRC, a match flag and the lowest matching ROM position
// (counted from 1, zero when nothing matches); the running CRC then restarts
// at all ones for the next message.
// Throughput is one byte per cycle while in_stall is low. A last byte goes
// from the input register through the byte fold XOR network and target
// compare into the result register, which drives the result port.
// When the receiver stalls, the result register holds its item and the input
// register still takes bytes; only a second last byte waits, and then
// in_stall rises. Reset empties both registers and loads the running CRC
// with all ones.
// Depends on crc32tm_pkg.
module crc32_target_matcher #(
  parameter int unsigned NUM_TARGETS = crc32tm_pkg::NUM_TARGETS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  crc32tm_pkg::in_item_t  in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output crc32tm_pkg::out_item_t out_item
);

  localparam int unsigned NUM_CMP =
    (NUM_TARGETS < crc32tm_pkg::ROM_WORDS) ? NUM_TARGETS : crc32tm_pkg::ROM_WORDS;

  logic                   s1_valid_r, s1_valid_nxt;
  crc32tm_pkg::in_item_t  s1_item_r;
  logic [31:0]            crc_r, crc_nxt;
  logic                   out_valid_r, out_valid_nxt;
  crc32tm_pkg::out_item_t out_item_r, out_item_nxt;

  logic        in_accept;
  logic        out_free;
  logic        s1_move;
  logic        s1_emit;
  logic [31:0] fold_c;
  logic [31:0] result_c;
  logic                          match_found_c;
  logic [crc32tm_pkg::IDX_W-1:0] match_index_c;

  assign out_free  = !out_valid_r || !out_stall;
  // A plain byte always drains; a last byte needs the result register free.
  assign s1_move   = s1_valid_r && (!s1_item_r.last_byte || out_free);
  assign s1_emit   = s1_move && s1_item_r.last_byte;
  assign in_stall  = s1_valid_r && !s1_move;
  assign in_accept = in_valid && !in_stall;

  assign fold_c   = crc32tm_pkg::fold_byte(crc_r, s1_item_r.data_byte);
  assign result_c = ~fold_c;

  // Scan from the highest active position down so the lowest match wins.
  always_comb begin
    match_found_c = 1'b0;
    match_index_c = '0;
    for (int i = NUM_CMP - 1; i >= 0; i--) begin
      if (result_c == crc32tm_pkg::TARGET_ROM[i]) begin
        match_found_c = 1'b1;
        match_index_c = crc32tm_pkg::IDX_W'(i + 1);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = in_accept || (s1_valid_r && !s1_move);
    crc_nxt      = crc_r;
    if (s1_move) begin
      crc_nxt = s1_item_r.last_byte ? crc32tm_pkg::CRC_INIT : fold_c;
    end
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    if (s1_emit) begin
      out_valid_nxt            = 1'b1;
      out_item_nxt.crc_value   = result_c;
      out_item_nxt.match_found = match_found_c;
      out_item_nxt.match_index = match_index_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      crc_r       <= crc32tm_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_item;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/crc32tm_checker.sv =====
// Port-level checker for the CRC-32 target matcher, bound to the top level.
// Depends on crc32tm_pkg and crc32_target_matcher_macros.svh.
`include "crc32_target_matcher_macros.svh"

module crc32tm_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_stall,
  input crc32tm_pkg::out_item_t out_item
);

  `CRC32TM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))
  `CRC32TM_ASSERT_IMPL(a_found_idx, out_valid && out_item.match_found, out_item.match_index != 4'd0)
  `CRC32TM_ASSERT_IMPL(a_miss_idx, out_valid && !out_item.match_found, out_item.match_index == 4'd0)
  `CRC32TM_ASSERT_IMPL(a_found_word, out_valid && out_item.match_found && out_item.match_index != 4'd0 && out_item.match_index <= 4'd14, out_item.crc_value == crc32tm_pkg::TARGET_ROM[out_item.match_index - 4'd1])

endmodule

bind crc32_target_matcher crc32tm_checker u_crc32tm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
